// ===== design/assert_macros.svh =====
// Assertion macros for the extractor's RTL, included by the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CSVX_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("csvx assertion failed");
`define CSVX_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("csvx forbidden condition seen");
`else
`define CSVX_ASSERT(label, clk, rst, prop)
`define CSVX_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== design/csvx_pkg.sv =====
// Types and constants of the CSV column field extractor.
package csvx_pkg;

   localparam int DATA_W = 8;
   localparam int COL_W = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int unsigned MAX_COLUMNS = 255;

   localparam logic [DATA_W-1:0] QUOTE_CHAR = 8'h22;
   localparam logic [DATA_W-1:0] COMMA_CHAR = 8'h2C;
   localparam logic [DATA_W-1:0] LF_CHAR = 8'h0A;

   localparam logic [CSR_INDEX_W-1:0] CSR_SELECTED_COLUMN = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS_PER_ROW = 8'd1;

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              byte_valid;
      logic              field_end;
      logic [COL_W-1:0]  field_column;
      logic              last_of_run;
   } result_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== design/csvx_wrap_div.sv =====
// Bit-serial remainder unit for the column counter wrap.
module csvx_wrap_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [csvx_pkg::COL_W-1:0]          dividend,
   input  logic [csvx_pkg::COL_W-1:0]          divisor,
   output csvx_pkg::div_status_type            status,
   output logic [csvx_pkg::COL_W-1:0]          remainder
);

   localparam int STEPS = csvx_pkg::COL_W;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [csvx_pkg::COL_W-1:0]    rem_ff, rem_in;
   logic [csvx_pkg::COL_W-1:0]    dvd_ff, dvd_in;
   logic [csvx_pkg::COL_W-1:0]    dsr_ff, dsr_in;
   logic [csvx_pkg::COL_W:0]      trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      trial    = {rem_ff, dvd_ff[csvx_pkg::COL_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         dvd_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = csvx_pkg::COL_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[csvx_pkg::COL_W-1:0];
         end
         dvd_in = {dvd_ff[csvx_pkg::COL_W-2:0], 1'b0};
         if (count_ff == LAST_STEP) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

// ===== design/csv_column_field_extractor_core.sv =====
// CSV column field extractor: quote-aware field splitter with column selection.
//
// One text byte is taken per cycle on req_ and the content bytes of the selected
// column (every column when the selection is zero) come out on rsp_, each field
// closed by an end beat carrying its column. A byte giving no result, or one
// result while rsp_tready is high, is accepted every cycle; a byte giving a content
// byte and a field end fills both result slots, so the next byte waits while the
// second beat drains. A write to columns_per_row starts the bit-serial wrap
// remainder unit; input and further writes wait for its 8 steps and result load.
`include "assert_macros.svh"
module csv_column_field_extractor_core #(
   parameter int unsigned MAX_COLUMNS = csvx_pkg::MAX_COLUMNS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // tdata: data_byte[7:0]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,
   input  logic                                  req_tlast,
   // tdata: out_byte[7:0], field_column[15:8]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [15:0]                           rsp_tdata,
   // tuser: byte_valid[0], field_end[1]
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [csvx_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [csvx_pkg::COL_W-1:0]            csr_data
);

   localparam int COL_W = csvx_pkg::COL_W;

   logic [COL_W-1:0]            sel_col_ff, sel_col_in;
   logic [COL_W-1:0]            cols_row_ff, cols_row_in;
   logic                        in_quotes_ff, in_quotes_in;
   logic                        quote_pending_ff, quote_pending_in;
   logic [COL_W-1:0]            column_ff, column_in;
   logic [COL_W-1:0]            rem_ff, rem_in;
   csvx_pkg::result_type        slot0_ff, slot0_in;
   csvx_pkg::result_type        slot1_ff, slot1_in;
   logic [1:0]                  count_ff, count_in;

   csvx_pkg::div_status_type    div_status;
   logic [COL_W-1:0]            div_rem;
   logic                        div_start;
   logic                        div_block;

   logic                        req_fire, rsp_fire, csr_fire;
   logic                        is_quote, is_sep, iq_eff;
   logic                        want_data, want_end, selected;
   logic                        emit_data, emit_end;
   logic [COL_W:0]              next_wide;
   logic [COL_W-1:0]            next_col;
   csvx_pkg::result_type        data_res, end_res;

   assign div_block  = div_status.busy | div_status.done;
   assign req_tready = !div_block && ((count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready));
   assign csr_ready  = !div_block;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign div_start  = csr_fire && (csr_index == csvx_pkg::CSR_COLUMNS_PER_ROW);

   csvx_wrap_div u_wrap_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (column_ff),
      .divisor   (csr_data),
      .status    (div_status),
      .remainder (div_rem)
   );

   always_comb begin
      is_quote  = (req_tdata == csvx_pkg::QUOTE_CHAR);
      is_sep    = (req_tdata == csvx_pkg::COMMA_CHAR) || (req_tdata == csvx_pkg::LF_CHAR);
      iq_eff    = in_quotes_ff;
      want_data = 1'b0;
      want_end  = 1'b0;
      in_quotes_in     = in_quotes_ff;
      quote_pending_in = quote_pending_ff;
      if (is_quote) begin
         if (quote_pending_ff) begin
            quote_pending_in = 1'b0;
            want_data        = 1'b1;
            want_end         = req_tlast && !in_quotes_ff;
         end else if (req_tlast) begin
            in_quotes_in = !in_quotes_ff;
            want_end     = in_quotes_ff;
         end else begin
            quote_pending_in = 1'b1;
         end
      end else begin
         if (quote_pending_ff) begin
            iq_eff = !in_quotes_ff;
         end
         quote_pending_in = 1'b0;
         in_quotes_in     = iq_eff;
         if (!iq_eff && is_sep) begin
            want_end = 1'b1;
         end else begin
            want_data = 1'b1;
            want_end  = req_tlast && !iq_eff;
         end
      end
   end

   always_comb begin
      selected  = (sel_col_ff == '0) || (column_ff == sel_col_ff);
      emit_data = want_data && selected;
      emit_end  = want_end && selected;
      next_wide = {1'b0, rem_ff} + 1'b1;
      if (cols_row_ff == '0) begin
         next_col = COL_W'(1);
      end else if (32'(next_wide) > MAX_COLUMNS) begin
         next_col = COL_W'(1);
      end else begin
         next_col = next_wide[COL_W-1:0];
      end
      data_res.out_byte     = req_tdata;
      data_res.byte_valid   = 1'b1;
      data_res.field_end    = 1'b0;
      data_res.field_column = column_ff;
      data_res.last_of_run  = !emit_end;
      end_res.out_byte      = '0;
      end_res.byte_valid    = 1'b0;
      end_res.field_end     = 1'b1;
      end_res.field_column  = column_ff;
      end_res.last_of_run   = 1'b1;
   end

   always_comb begin
      sel_col_in  = sel_col_ff;
      cols_row_in = cols_row_ff;
      column_in   = column_ff;
      rem_in      = rem_ff;
      slot0_in    = slot0_ff;
      slot1_in    = slot1_ff;
      count_in    = count_ff;
      if (csr_fire) begin
         case (csr_index)
            csvx_pkg::CSR_SELECTED_COLUMN: sel_col_in = csr_data;
            csvx_pkg::CSR_COLUMNS_PER_ROW: cols_row_in = csr_data;
            default: ;
         endcase
      end
      if (div_status.done) begin
         rem_in = div_rem;
      end
      if (rsp_fire) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 1'b1;
      end
      if (req_fire) begin
         if (want_end) begin
            column_in = next_col;
            rem_in    = (next_col == cols_row_ff) ? '0 : next_col;
         end
         if (emit_data) begin
            slot0_in = data_res;
         end else begin
            slot0_in = end_res;
         end
         slot1_in = end_res;
         count_in = {1'b0, emit_data} + {1'b0, emit_end};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_col_ff       <= '0;
         cols_row_ff      <= '0;
         in_quotes_ff     <= 1'b0;
         quote_pending_ff <= 1'b0;
         column_ff        <= COL_W'(1);
         rem_ff           <= COL_W'(1);
         count_ff         <= 2'd0;
      end else begin
         sel_col_ff  <= sel_col_in;
         cols_row_ff <= cols_row_in;
         column_ff   <= column_in;
         rem_ff      <= rem_in;
         count_ff    <= count_in;
         if (req_fire) begin
            in_quotes_ff     <= in_quotes_in;
            quote_pending_ff <= quote_pending_in;
         end
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {slot0_ff.field_column, slot0_ff.out_byte};
   assign rsp_tuser  = {slot0_ff.field_end, slot0_ff.byte_valid};
   assign rsp_tlast  = slot0_ff.last_of_run;

   `CSVX_ASSERT_NEVER(a_flags_exclusive, clock, reset, rsp_tvalid && slot0_ff.byte_valid && slot0_ff.field_end)
   `CSVX_ASSERT_NEVER(a_no_beat_while_div, clock, reset, req_fire && div_block)
   `CSVX_ASSERT_NEVER(a_count_range, clock, reset, count_ff == 2'd3)
   `CSVX_ASSERT(a_pair_order, clock, reset, (count_ff == 2'd2) |-> (slot0_ff.byte_valid && !slot0_ff.last_of_run && slot1_ff.field_end))
   `CSVX_ASSERT_NEVER(a_column_nonzero, clock, reset, column_ff == '0)

endmodule

// ===== sim/csv_column_field_extractor_core_tb.sv =====
// Self-checking testbench for the CSV column field extractor core.
module csv_column_field_extractor_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_beat_type;

   typedef enum int {
      SINK_ALWAYS,
      SINK_COIN,
      SINK_BURSTY
   } sink_mode_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = '0;
   logic             req_tlast = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [15:0]      rsp_tdata;
   logic [1:0]       rsp_tuser;
   logic             rsp_tlast;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [csvx_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [csvx_pkg::COL_W-1:0]       csr_data = '0;

   text_beat_type        text_q[$];
   csvx_pkg::result_type field_results[$];

   logic             quoted;
   logic             quote_held;
   logic [7:0]       col_count;
   logic [7:0]       sel_col;
   logic [7:0]       row_cols;
   int               step_results;

   sink_mode_type    sink_mode = SINK_ALWAYS;
   int               gap_max = 0;
   int               bytes_in = 0;
   int               beats_out = 0;
   int               csr_writes = 0;
   int               errors = 0;
   int               idle_cycles = 0;

   csv_column_field_extractor_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void log_result(logic [7:0] b, logic valid, logic fend);
      csvx_pkg::result_type r;
      if (sel_col == 8'd0 || col_count == sel_col) begin
         r.out_byte = b;
         r.byte_valid = valid;
         r.field_end = fend;
         r.field_column = col_count;
         r.last_of_run = 1'b0;
         field_results.insert(field_results.size(), r);
         step_results++;
      end
   endfunction

   function automatic void close_field();
      int unsigned nxt;
      log_result(8'd0, 1'b0, 1'b1);
      if (row_cols != 8'd0) begin
         nxt = (col_count % row_cols) + 1;
         if (nxt > csvx_pkg::MAX_COLUMNS)
            nxt = 1;
      end else begin
         nxt = 1;
      end
      col_count = 8'(nxt);
      if (col_count == 8'd0)
         col_count = 8'd1;
   endfunction

   function automatic void split_byte(logic [7:0] b, logic le);
      step_results = 0;
      if (b == csvx_pkg::QUOTE_CHAR) begin
         if (quote_held) begin
            quote_held = 1'b0;
            log_result(b, 1'b1, 1'b0);
         end else if (le) begin
            quoted = !quoted;
         end else begin
            quote_held = 1'b1;
         end
         if (le && !quote_held && !quoted)
            close_field();
      end else begin
         if (quote_held) begin
            quote_held = 1'b0;
            quoted = !quoted;
         end
         if (!quoted && (b == csvx_pkg::COMMA_CHAR || b == csvx_pkg::LF_CHAR)) begin
            close_field();
         end else begin
            log_result(b, 1'b1, 1'b0);
            if (le && !quoted)
               close_field();
         end
      end
      if (step_results > 0)
         field_results[field_results.size() - 1].last_of_run = 1'b1;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == csvx_pkg::QUOTE_CHAR || b == csvx_pkg::COMMA_CHAR
             || b == csvx_pkg::LF_CHAR);
      return b;
   endfunction

   always @(posedge clock) begin : drive_req
      text_beat_type nxt;
      int burst_left;
      int gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (text_q.size() > 0) begin
            nxt = text_q.pop_front();
            req_tdata <= nxt.data;
            req_tlast <= nxt.last;
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : drive_sink
      int stall_left;
      logic ready;
      ready = 1'b1;
      if (reset) begin
         stall_left = 0;
         ready = 1'b0;
      end else begin
         case (sink_mode)
            SINK_COIN: begin
               ready = 1'($urandom_range(0, 1));
            end
            SINK_BURSTY: begin
               if (stall_left > 0) begin
                  stall_left--;
                  ready = 1'b0;
               end else if ($urandom_range(0, 11) == 0) begin
                  stall_left = $urandom_range(1, 12);
                  ready = 1'b0;
               end
            end
            default: ready = 1'b1;
         endcase
      end
      rsp_tready <= ready;
   end

   always @(posedge clock) begin : watch_ports
      csvx_pkg::result_type got;
      csvx_pkg::result_type want;
      if (reset) begin
         quoted = 1'b0;
         quote_held = 1'b0;
         col_count = 8'd1;
         sel_col = 8'd0;
         row_cols = 8'd0;
         field_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               csvx_pkg::CSR_SELECTED_COLUMN: sel_col = csr_data;
               csvx_pkg::CSR_COLUMNS_PER_ROW: row_cols = csr_data;
               default: ;
            endcase
            csr_writes++;
         end
         if (req_tvalid && req_tready) begin
            split_byte(req_tdata, req_tlast);
            bytes_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte = rsp_tdata[7:0];
            got.field_column = rsp_tdata[15:8];
            got.byte_valid = rsp_tuser[0];
            got.field_end = rsp_tuser[1];
            got.last_of_run = rsp_tlast;
            beats_out++;
            if (field_results.size() == 0) begin
               $error("result beat with nothing expected: tdata %04h tuser %0b",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = field_results.pop_front();
               check_field("out_byte", want.out_byte, got.out_byte);
               check_field("byte_valid", want.byte_valid, got.byte_valid);
               check_field("field_end", want.field_end, got.field_end);
               check_field("field_column", want.field_column, got.field_column);
               check_field("last_of_run", want.last_of_run, got.last_of_run);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $error("no beat moved for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic add_beat(logic [7:0] data, logic last);
      text_beat_type t;
      t.data = data;
      t.last = last;
      text_q.insert(text_q.size(), t);
   endtask

   task automatic wait_quiet();
      while (text_q.size() != 0 || req_tvalid || field_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [csvx_pkg::CSR_INDEX_W-1:0] index,
                            logic [csvx_pkg::COL_W-1:0] value);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_row();
      text_beat_type row[$];
      text_beat_type t;
      int nfields;
      int len;
      nfields = $urandom_range(1, 7);
      t.last = 1'b0;
      for (int f = 0; f < nfields; f++) begin
         if (f > 0) begin
            t.data = csvx_pkg::COMMA_CHAR;
            row.insert(row.size(), t);
         end
         len = $urandom_range(0, 5);
         if ($urandom_range(0, 2) == 0) begin
            t.data = csvx_pkg::QUOTE_CHAR;
            row.insert(row.size(), t);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 7))
                  0: t.data = csvx_pkg::COMMA_CHAR;
                  1: t.data = csvx_pkg::LF_CHAR;
                  2: begin
                     t.data = csvx_pkg::QUOTE_CHAR;
                     row.insert(row.size(), t);
                  end
                  default: t.data = plain_char();
               endcase
               row.insert(row.size(), t);
            end
            t.data = csvx_pkg::QUOTE_CHAR;
            row.insert(row.size(), t);
         end else begin
            for (int i = 0; i < len; i++) begin
               t.data = plain_char();
               row.insert(row.size(), t);
            end
         end
      end
      case ($urandom_range(0, 5))
         0: begin
            t.data = csvx_pkg::COMMA_CHAR;
            row.insert(row.size(), t);
         end
         1: begin
            t.data = csvx_pkg::LF_CHAR;
            row.insert(row.size(), t);
         end
         default: ;
      endcase
      if (row.size() == 0) begin
         t.data = plain_char();
         row.insert(row.size(), t);
      end
      t = row.pop_back();
      t.last = 1'b1;
      row.insert(row.size(), t);
      foreach (row[i])
         text_q.insert(text_q.size(), row[i]);
   endtask

   task automatic run_phase(logic [7:0] sel, logic [7:0] cols, sink_mode_type sink,
                            int gaps, int budget, bit wide);
      int queued;
      int n;
      wait_quiet();
      write_reg(csvx_pkg::CSR_SELECTED_COLUMN, sel);
      write_reg(csvx_pkg::CSR_COLUMNS_PER_ROW, cols);
      sink_mode = sink;
      gap_max = gaps;
      queued = 0;
      if (wide) begin
         // reach the top column: 254 empty fields, then a real one
         for (int i = 0; i < 254; i++)
            add_beat(csvx_pkg::COMMA_CHAR, 1'b0);
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++)
            add_beat(plain_char(), 1'b0);
         add_beat(csvx_pkg::COMMA_CHAR, 1'b1);
      end
      while (queued < budget) begin
         n = text_q.size();
         case ($urandom_range(0, 9))
            7, 8: begin
               repeat ($urandom_range(1, 6))
                  add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            9: begin
               add_beat(csvx_pkg::QUOTE_CHAR, 1'b0);
               repeat ($urandom_range(0, 4))
                  add_beat(plain_char(), 1'b0);
               add_beat(plain_char(), 1'b1);
            end
            default: add_row();
         endcase
         queued += text_q.size() - n;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_beat(8'h00, 1'b1);
      add_beat(8'hFF, 1'b0);
      add_beat(csvx_pkg::COMMA_CHAR, 1'b0);
      add_beat(csvx_pkg::QUOTE_CHAR, 1'b0);
      add_beat(8'h78, 1'b0);
      add_beat(csvx_pkg::COMMA_CHAR, 1'b0);
      add_beat(csvx_pkg::LF_CHAR, 1'b1);
      add_beat(csvx_pkg::QUOTE_CHAR, 1'b0);
      add_beat(csvx_pkg::QUOTE_CHAR, 1'b0);
      add_beat(csvx_pkg::QUOTE_CHAR, 1'b0);
      add_beat(8'h79, 1'b0);
      add_beat(csvx_pkg::COMMA_CHAR, 1'b1);
      add_beat(csvx_pkg::QUOTE_CHAR, 1'b1);
      add_beat(csvx_pkg::QUOTE_CHAR, 1'b1);
      add_beat(csvx_pkg::QUOTE_CHAR, 1'b0);
      add_beat(csvx_pkg::QUOTE_CHAR, 1'b1);
      add_beat(csvx_pkg::LF_CHAR, 1'b0);
      add_beat(csvx_pkg::QUOTE_CHAR, 1'b0);
      add_beat(csvx_pkg::COMMA_CHAR, 1'b0);
      add_beat(csvx_pkg::QUOTE_CHAR, 1'b0);
      add_beat(csvx_pkg::LF_CHAR, 1'b1);
      add_beat(8'h7F, 1'b0);
      add_beat(8'h80, 1'b1);

      run_phase(8'd0, 8'd0, SINK_ALWAYS, 0, 70, 1'b0);
      run_phase(8'd1, 8'd3, SINK_COIN, 3, 80, 1'b0);
      run_phase(8'd2, 8'd4, SINK_BURSTY, 6, 80, 1'b0);
      run_phase(8'd255, 8'd255, SINK_COIN, 2, 20, 1'b1);
      run_phase(8'd0, 8'd255, SINK_BURSTY, 0, 90, 1'b0);
      run_phase(8'd1, 8'd1, SINK_ALWAYS, 4, 70, 1'b0);
      run_phase(8'($urandom_range(0, 5)), 8'($urandom_range(0, 6)),
                SINK_BURSTY, 2, 100, 1'b0);
      run_phase(8'd0, 8'd2, SINK_COIN, 1, 100, 1'b0);

      wait_quiet();
      repeat (8) @(posedge clock);
      if (field_results.size() != 0) begin
         $error("%0d expected result beats never arrived", field_results.size());
         errors++;
      end
      $display("Run moved %0d text bytes in and %0d result beats out,",
               bytes_in, beats_out);
      $display("with %0d register writes; covered quoting, doubled quotes, line ends, %s",
               csr_writes, "trailing separators and column wrap");
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
